// ===== rtl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and defaults of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// Command codes of a request transaction.
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_ALLOC   = 2'd1;
	localparam logic [1:0] CMD_RESTORE = 2'd2;

	// Fit policy codes.
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	// Response status codes.
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_LOADED   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RESTORED = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] size_value;
		logic [7:0]  request_id;
	} fpba_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        granted;
		logic [3:0]  block_index;
		logic [15:0] leftover_size;
		logic [7:0]  echo_id;
	} fpba_rsp_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_FINISH
	} fpba_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic issue;
		logic finish;
	} fpba_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic more;
		logic rd_pending;
		logic rsp_free;
	} fpba_sts_t;

endpackage

// ===== rtl/fpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpba_ctrl
// Controller state machine: takes a request, walks the table, finishes.
// ----------------------------------------------------------------------------
module fpba_ctrl import fpba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_cmd,
	input  fpba_sts_t  sts,
	output logic       req_stall,
	output fpba_ctrl_t ctrl
);

	fpba_state_t state_q;
	fpba_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		req_stall   = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctrl.accept = 1'b1;
					// Allocate and restore both sweep the table entries.
					if (req_cmd == CMD_ALLOC || req_cmd == CMD_RESTORE) begin
						state_d = FSM_WALK;
					end else begin
						state_d = FSM_FINISH;
					end
				end
			end
			FSM_WALK: begin
				ctrl.issue = sts.more;
				if (!sts.more && !sts.rd_pending) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (sts.rsp_free) begin
					ctrl.finish = 1'b1;
					state_d     = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/fpba_dp.sv =====
// ----------------------------------------------------------------------------
// fpba_dp
// Datapath: size tables, scan pointer, fit comparison and response register.
// ----------------------------------------------------------------------------
module fpba_dp import fpba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fpba_req_t  req,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_data,
	input  fpba_ctrl_t ctrl,
	input  logic       rsp_stall,
	output fpba_sts_t  sts,
	output logic       rsp_valid,
	output fpba_rsp_t  rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	logic [SIZE_BITS-1:0] orig_mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] rem_mem  [MAX_BLOCKS];

	logic [1:0]           fit_mode_q;
	logic [1:0]           cmd_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [7:0]           id_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        ptr_q;
	logic                 rd_valid_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [SIZE_BITS-1:0] orig_rd_s1;
	logic [SIZE_BITS-1:0] rem_rd_s1;
	logic                 found_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic [IW-1:0]        best_idx_q;
	logic                 rsp_valid_q;
	fpba_rsp_t            rsp_q;

	logic                 take;
	logic                 full;
	logic [SIZE_BITS-1:0] leftover;
	fpba_rsp_t            rsp_d;

	assign full     = (count_q == CW'(MAX_BLOCKS));
	assign leftover = best_val_q - size_q;

	assign sts.more       = (ptr_q < count_q);
	assign sts.rd_pending = rd_valid_s1;
	assign sts.rsp_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Candidate selection; ties keep the earlier block.
	always_comb begin
		take = 1'b0;
		if (rd_valid_s1 && cmd_q == CMD_ALLOC && rem_rd_s1 >= size_q) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == MODE_BEST) begin
				take = (rem_rd_s1 < best_val_q);
			end else if (fit_mode_q == MODE_WORST) begin
				take = (rem_rd_s1 > best_val_q);
			end
		end
	end

	always_comb begin
		rsp_d         = '0;
		rsp_d.echo_id = id_q;
		rsp_d.status  = ST_NOFIT;
		case (cmd_q)
			CMD_LOAD: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					rsp_d.status        = ST_LOADED;
					rsp_d.block_index   = 4'(count_q);
					rsp_d.leftover_size = 16'(size_q);
				end
			end
			CMD_ALLOC: begin
				if (found_q) begin
					rsp_d.status        = ST_GRANTED;
					rsp_d.granted       = 1'b1;
					rsp_d.block_index   = 4'(best_idx_q);
					rsp_d.leftover_size = 16'(leftover);
				end
			end
			CMD_RESTORE: begin
				rsp_d.status = ST_RESTORED;
			end
			default: begin
				rsp_d.status = ST_NOFIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q  <= MODE_FIRST;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fit_mode_q <= cfg_data;
			end
			if (ctrl.accept) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else if (ctrl.issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			rd_valid_s1 <= ctrl.issue;
			if (take) begin
				found_q <= 1'b1;
			end
			if (ctrl.finish && cmd_q == CMD_LOAD && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (ctrl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q  <= req.cmd;
			size_q <= SIZE_BITS'(req.size_value);
			id_q   <= req.request_id;
		end
		if (take) begin
			best_val_q <= rem_rd_s1;
			best_idx_q <= rd_idx_s1;
		end
		rd_idx_s1 <= ptr_q[IW-1:0];
		if (ctrl.finish) begin
			rsp_q <= rsp_d;
		end
	end

	// Table memories: one read address, one write port each.
	always_ff @(posedge clk) begin
		orig_rd_s1 <= orig_mem[ptr_q[IW-1:0]];
		if (ctrl.finish && cmd_q == CMD_LOAD && !full) begin
			orig_mem[count_q[IW-1:0]] <= size_q;
		end
	end

	always_ff @(posedge clk) begin
		rem_rd_s1 <= rem_mem[ptr_q[IW-1:0]];
		if (ctrl.finish && cmd_q == CMD_LOAD && !full) begin
			rem_mem[count_q[IW-1:0]] <= size_q;
		end else if (ctrl.finish && cmd_q == CMD_ALLOC && found_q) begin
			rem_mem[best_idx_q] <= leftover;
		end else if (rd_valid_s1 && cmd_q == CMD_RESTORE) begin
			rem_mem[rd_idx_s1] <= orig_rd_s1;
		end
	end

endmodule

// ===== rtl/fit_policy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block table allocator with first, best and worst fit policies.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req) carries one command per
// transaction: load a block size, allocate a request, or restore all
// remaining sizes. Every request yields exactly one response transaction on
// rsp_valid, rsp_stall and rsp. The fit policy is set through the cfg
// channel, which is always ready; write it only while the block is idle.
// The block works on one request at a time. Load and unused commands go
// straight from acceptance to the response. Allocate and restore walk the
// N loaded blocks through one memory read port, one entry per cycle, and
// the walk sets the rate.
// At reset the block count, fit policy (first fit) and response valid are
// cleared; table contents are not, as only loaded entries are ever read.
// When the receiver stalls, the finished response is held in the output
// register while the next request is still taken and worked on; that
// request waits at its last step until the output register is free.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit import fpba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  fpba_req_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output fpba_rsp_t  rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	fpba_ctrl_t ctrl;
	fpba_sts_t  sts;

	// The policy register can take a write in any cycle.
	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.sts       (sts),
		.req_stall (req_stall),
		.ctrl      (ctrl)
	);

	fpba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// A request transaction is followed by a busy cycle, never by another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous request was in work");

	// The grant flag agrees with the status code.
	a_grant_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.granted == (rsp.status == ST_GRANTED))
		else $error("granted flag disagrees with status");

	// Only grants and loads report an index and a size.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_GRANTED && rsp.status != ST_LOADED
		|-> rsp.block_index == '0 && rsp.leftover_size == '0)
		else $error("index or size reported on a response without a block");

endmodule
